### hw/rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, widths and constants of the pressure sensor compensation
// datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

    // field widths
    localparam int RAW_W     = 24;  // raw conversion results
    localparam int COEF_W    = 16;  // calibration coefficients
    localparam int CFG_IDX_W = 3;   // register index
    localparam int P_W       = 21;  // pressure result
    localparam int TC_W      = 19;  // temperature result

    // internal widths, sized from the value ranges
    localparam int DT_W    = 25;  // temperature difference
    localparam int D_W     = 18;  // temperature minus reference point
    localparam int OFF_W   = 36;  // offset
    localparam int SENS_W  = 35;  // sensitivity
    localparam int TI_W    = 17;  // second-order temperature term
    localparam int DD_W    = 34;  // square of the temperature deviation
    localparam int TEMP_W  = 19;  // first-order temperature
    localparam int T_W     = 20;  // corrected temperature before clamp
    localparam int SDIFF_W = 37;  // sensitivity minus correction
    localparam int ODIFF_W = 38;  // offset minus correction

    // 20.00 degrees, the second-order threshold
    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

    // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^30
    localparam int             RECIP_W     = 28;
    localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798692;
    localparam int             RECIP_SHIFT = 34;

    // saturation limits, one bit wider than the result
    localparam logic signed [P_W:0]  P_MAX_X = 22'sd1048575;
    localparam logic signed [P_W:0]  P_MIN_X = -22'sd1048576;
    localparam logic signed [T_W-1:0] T_MAX_X = 20'sd262143;
    localparam logic signed [T_W-1:0] T_MIN_X = -20'sd262144;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_COEFF      = 3'd0,
        REG_OFF_COEFF       = 3'd1,
        REG_SENS_TEMP_COEFF = 3'd2,
        REG_OFF_TEMP_COEFF  = 3'd3,
        REG_REF_TEMP        = 3'd4,
        REG_TEMP_SENS_COEFF = 3'd5
    } psc_reg_t;

    // calibration coefficient set
    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] sens_temp;
        logic [COEF_W-1:0] off_temp;
        logic [COEF_W-1:0] ref_t;
        logic [COEF_W-1:0] temp_sens;
    } psc_coeff_t;

    // hand-over from the front stages to the pressure stages
    typedef struct packed {
        logic                      valid;
        logic [RAW_W-1:0]          d1;
        logic signed [SDIFF_W-1:0] sdiff;
        logic signed [ODIFF_W-1:0] odiff;
        logic signed [T_W-1:0]     t;
    } psc_mid_t;

endpackage

### hw/rtl/pressure_sensor_compensation.sv
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Second-order compensation of raw pressure and temperature conversions,
// six calibration coefficient registers and a fully pipelined datapath.
// ----------------------------------------------------------------------------
// A pair is taken on every clock edge with start high; busy is always low.
// Results are marked by done for one cycle and come out in the order the
// pairs went in, one per cycle at most. Of the 13 register stages, two hold
// the D1 * sensitivity product, first as partial products, then recombined.
// done cannot be held off, so the receiver must take every result in the
// cycle it is shown. The user must write coefficients through cfg_wr_en,
// cfg_index and cfg_data only while no pair is in flight; the block does not
// enforce this. Indexes beyond five are ignored.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psc_pkg::COEF_W-1:0]          cfg_data,
    // input transfer
    input  logic                                start,
    output logic                                busy,
    input  logic [psc_pkg::RAW_W-1:0]           pressure_raw,
    input  logic [psc_pkg::RAW_W-1:0]           temperature_raw,
    // result transfer
    output logic                                done,
    output logic signed [psc_pkg::P_W-1:0]      pressure_mbar,
    output logic signed [psc_pkg::TC_W-1:0]     temperature_centi,
    output logic                                out_of_range
);
    import psc_pkg::*;

    psc_coeff_t coeff_reg;
    psc_mid_t   mid;
    logic       in_valid;

    // the pipeline takes a pair every cycle
    assign busy     = 1'b0;
    assign in_valid = start & ~busy;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SENS_COEFF:      coeff_reg.sens      <= cfg_data;
                REG_OFF_COEFF:       coeff_reg.off       <= cfg_data;
                REG_SENS_TEMP_COEFF: coeff_reg.sens_temp <= cfg_data;
                REG_OFF_TEMP_COEFF:  coeff_reg.off_temp  <= cfg_data;
                REG_REF_TEMP:        coeff_reg.ref_t     <= cfg_data;
                REG_TEMP_SENS_COEFF: coeff_reg.temp_sens <= cfg_data;
                default:             coeff_reg           <= coeff_reg;
            endcase
        end
    end

    // temperature, offset and sensitivity stages
    psc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .d1       (pressure_raw),
        .d2       (temperature_raw),
        .coeff    (coeff_reg),
        .mid      (mid)
    );

    // pressure stages and output registers
    psc_pressure u_pressure (
        .clk               (clk),
        .rst_n             (rst_n),
        .mid               (mid),
        .done              (done),
        .pressure_mbar     (pressure_mbar),
        .temperature_centi (temperature_centi),
        .out_of_range      (out_of_range)
    );

endmodule

### hw/rtl/psc_front.sv
// ----------------------------------------------------------------------------
// psc_front
// Six pipeline stages: temperature difference, first-order temperature,
// offset and sensitivity, the low-temperature correction terms and their subtraction.
// ----------------------------------------------------------------------------
module psc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [psc_pkg::RAW_W-1:0]     d1,
    input  logic [psc_pkg::RAW_W-1:0]     d2,
    input  psc_pkg::psc_coeff_t           coeff,
    output psc_pkg::psc_mid_t             mid
);
    import psc_pkg::*;

    // stage valid bits
    logic [5:0] vld_reg;

    // raw pressure travels along
    logic [RAW_W-1:0] d1_1_reg, d1_2_reg, d1_3_reg, d1_4_reg, d1_5_reg, d1_6_reg;

    // stage 1
    logic signed [DT_W-1:0] dt_next, dt1_reg;
    // stage 2
    logic signed [41:0] mt_next, mt2_reg;
    logic signed [41:0] mo_next, mo2_reg;
    logic signed [41:0] ms_next, ms2_reg;
    logic signed [2*DT_W-1:0] mdd_next, mdd2_reg;
    // stage 3
    logic signed [41:0]       mt_bias, mo_bias, ms_bias;
    logic [51:0]              ti_sum;
    logic signed [D_W-1:0]    d_next, d3_reg;
    logic signed [OFF_W-1:0]  oterm_next, oterm3_reg;
    logic signed [SENS_W-1:0] sterm_next, sterm3_reg;
    logic [TI_W-1:0]          ti_next, ti3_reg, ti4_reg;
    // stage 4
    logic signed [2*D_W-1:0]  sq;
    logic [DD_W-1:0]          dd_next, dd4_reg;
    logic signed [OFF_W-1:0]  off_next, off4_reg, off5_reg;
    logic signed [SENS_W-1:0] sens_next, sens4_reg, sens5_reg;
    logic signed [TEMP_W-1:0] temp_next, temp4_reg;
    logic                     cold_next, cold4_reg;
    // stage 5
    logic [DD_W+4:0]          o31;
    logic [DD_W+5:0]          s63;
    logic [OFF_W-1:0]         offi_next, offi5_reg;
    logic [SENS_W-1:0]        sensi_next, sensi5_reg;
    logic signed [T_W-1:0]    t_next, t5_reg, t6_reg;
    // stage 6
    logic signed [SDIFF_W-1:0] sdiff_next, sdiff6_reg;
    logic signed [ODIFF_W-1:0] odiff_next, odiff6_reg;

    // dT = D2 - C5*256
    assign dt_next = $signed({1'b0, d2}) - $signed({1'b0, coeff.ref_t, 8'b0});

    // products of dT with the temperature coefficients, and dT squared
    assign mt_next  = dt1_reg * $signed({1'b0, coeff.temp_sens});
    assign mo_next  = dt1_reg * $signed({1'b0, coeff.off_temp});
    assign ms_next  = dt1_reg * $signed({1'b0, coeff.sens_temp});
    assign mdd_next = dt1_reg * dt1_reg;

    // power-of-two divisions truncating toward zero
    assign mt_bias    = mt2_reg + $signed({19'b0, {23{mt2_reg[41]}}});
    assign mo_bias    = mo2_reg + $signed({36'b0, {6{mo2_reg[41]}}});
    assign ms_bias    = ms2_reg + $signed({35'b0, {7{ms2_reg[41]}}});
    assign d_next     = mt_bias[40:23];
    assign oterm_next = mo_bias[41:6];
    assign sterm_next = ms_bias[41:7];

    // 11*dT^2 / 2^35, dT^2 is never negative
    assign ti_sum = {1'b0, mdd2_reg[47:0], 3'b0} + {3'b0, mdd2_reg[47:0], 1'b0}
                  + {4'b0, mdd2_reg[47:0]};
    assign ti_next = ti_sum[51:35];

    // first-order offset, sensitivity and temperature
    assign sq        = d3_reg * d3_reg;
    assign dd_next   = sq[DD_W-1:0];
    assign off_next  = $signed({3'b0, coeff.off, 17'b0}) + oterm3_reg;
    assign sens_next = $signed({3'b0, coeff.sens, 16'b0}) + sterm3_reg;
    assign temp_next = TEMP_REF + $signed({d3_reg[D_W-1], d3_reg});
    assign cold_next = d3_reg[D_W-1];

    // second-order terms below 20.00 degrees
    assign o31        = {dd4_reg, 5'b0} - {5'b0, dd4_reg};
    assign s63        = {dd4_reg, 6'b0} - {6'b0, dd4_reg};
    assign offi_next  = cold4_reg ? o31[DD_W+4:3] : '0;
    assign sensi_next = cold4_reg ? s63[DD_W+5:5] : '0;
    assign t_next     = $signed({temp4_reg[TEMP_W-1], temp4_reg})
                      - (cold4_reg ? $signed({3'b0, ti4_reg}) : $signed({T_W{1'b0}}));

    // corrected sensitivity and offset
    assign sdiff_next = $signed({{2{sens5_reg[SENS_W-1]}}, sens5_reg})
                      - $signed({2'b0, sensi5_reg});
    assign odiff_next = $signed({{2{off5_reg[OFF_W-1]}}, off5_reg})
                      - $signed({2'b0, offi5_reg});

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        d1_1_reg   <= d1;
        dt1_reg    <= dt_next;

        d1_2_reg   <= d1_1_reg;
        mt2_reg    <= mt_next;
        mo2_reg    <= mo_next;
        ms2_reg    <= ms_next;
        mdd2_reg   <= mdd_next;

        d1_3_reg   <= d1_2_reg;
        d3_reg     <= d_next;
        oterm3_reg <= oterm_next;
        sterm3_reg <= sterm_next;
        ti3_reg    <= ti_next;

        d1_4_reg   <= d1_3_reg;
        dd4_reg    <= dd_next;
        off4_reg   <= off_next;
        sens4_reg  <= sens_next;
        temp4_reg  <= temp_next;
        cold4_reg  <= cold_next;
        ti4_reg    <= ti3_reg;

        d1_5_reg   <= d1_4_reg;
        offi5_reg  <= offi_next;
        sensi5_reg <= sensi_next;
        off5_reg   <= off4_reg;
        sens5_reg  <= sens4_reg;
        t5_reg     <= t_next;

        d1_6_reg   <= d1_5_reg;
        sdiff6_reg <= sdiff_next;
        odiff6_reg <= odiff_next;
        t6_reg     <= t5_reg;
    end

    // hand-over
    assign mid.valid = vld_reg[5];
    assign mid.d1    = d1_6_reg;
    assign mid.sdiff = sdiff6_reg;
    assign mid.odiff = odiff6_reg;
    assign mid.t     = t6_reg;

endmodule

### hw/rtl/psc_pressure.sv
// ----------------------------------------------------------------------------
// psc_pressure
// Seven pipeline stages: split D1 * sensitivity product, scaling, offset
// subtraction, division by 100 and output saturation.
// ----------------------------------------------------------------------------
module psc_pressure (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psc_pkg::psc_mid_t             mid,
    output logic                          done,
    output logic signed [psc_pkg::P_W-1:0]  pressure_mbar,
    output logic signed [psc_pkg::TC_W-1:0] temperature_centi,
    output logic                          out_of_range
);
    import psc_pkg::*;

    localparam int LO_W   = 19;
    localparam int PLO_W  = RAW_W + LO_W;                 // 43
    localparam int PHI_W  = RAW_W + 1 + SDIFF_W - LO_W;   // 43
    localparam int PROD_W = PHI_W + LO_W;                 // 62
    localparam int P1_W   = PROD_W - 21;                  // 41
    localparam int Q_W    = P1_W + 1;                     // 42
    localparam int MAG_W  = Q_W - 15;                     // 27
    localparam int RP_W   = MAG_W + RECIP_W;              // 55

    // stage valid bits, plus the output strobe
    logic [5:0] vld_reg;
    logic       done_reg;

    // temperature travels along
    logic signed [T_W-1:0] t_pipe_reg [6];

    // stage 7
    logic [PLO_W-1:0]         plo_next, plo7_reg;
    logic signed [PHI_W-1:0]  phi_next, phi7_reg;
    logic signed [ODIFF_W-1:0] odiff7_reg, odiff8_reg, odiff9_reg;
    // stage 8
    logic signed [PROD_W-1:0] prod_next, prod8_reg;
    // stage 9
    logic signed [PROD_W-1:0] prod_bias;
    logic signed [P1_W-1:0]   p1_next, p1_9_reg;
    // stage 10
    logic signed [Q_W-1:0]    q_next, q10_reg;
    // stage 11
    logic [Q_W-1:0]           q_abs;
    logic [MAG_W-1:0]         mag_next, mag11_reg;
    logic                     neg11_reg, neg12_reg;
    // stage 12
    logic [RP_W-1:0]          rp_next, rp12_reg;
    // stage 13
    logic [P_W-1:0]           quo;
    logic signed [P_W:0]      p_full;
    logic signed [P_W-1:0]    p_next;
    logic signed [TC_W-1:0]   t_next;
    logic                     p_sat, t_sat;

    // D1 * (SENS - SENSi) as two partial products
    assign plo_next = mid.d1 * mid.sdiff[LO_W-1:0];
    assign phi_next = $signed({1'b0, mid.d1}) * $signed(mid.sdiff[SDIFF_W-1:LO_W]);

    // recombine the partial products
    assign prod_next = $signed({phi7_reg, {LO_W{1'b0}}}) + $signed({{LO_W{1'b0}}, plo7_reg});

    // divide by 2^21 truncating toward zero
    assign prod_bias = prod8_reg + $signed({{(PROD_W-21){1'b0}}, {21{prod8_reg[PROD_W-1]}}});
    assign p1_next   = prod_bias[PROD_W-1:21];

    // subtract corrected offset
    assign q_next = $signed({p1_9_reg[P1_W-1], p1_9_reg})
                  - $signed({{(Q_W-ODIFF_W){odiff9_reg[ODIFF_W-1]}}, odiff9_reg});

    // magnitude divided by 2^15, sign restored after the division by 100
    assign q_abs    = q10_reg[Q_W-1] ? $unsigned(-q10_reg) : $unsigned(q10_reg);
    assign mag_next = q_abs[Q_W-1:15];

    // division by 100 through the reciprocal
    assign rp_next = mag11_reg * RECIP_100;

    // sign and saturation
    assign quo    = rp12_reg[RECIP_SHIFT+P_W-1:RECIP_SHIFT];
    assign p_full = neg12_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    always_comb
    begin
        p_sat = 1'b1;
        priority if (p_full > P_MAX_X)
            p_next = P_MAX_X[P_W-1:0];
        else if (p_full < P_MIN_X)
            p_next = P_MIN_X[P_W-1:0];
        else
        begin
            p_next = p_full[P_W-1:0];
            p_sat  = 1'b0;
        end
    end

    always_comb
    begin
        t_sat = 1'b1;
        priority if (t_pipe_reg[5] > T_MAX_X)
            t_next = T_MAX_X[TC_W-1:0];
        else if (t_pipe_reg[5] < T_MIN_X)
            t_next = T_MIN_X[TC_W-1:0];
        else
        begin
            t_next = t_pipe_reg[5][TC_W-1:0];
            t_sat  = 1'b0;
        end
    end

    // valid bits and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[4:0], mid.valid};
            done_reg <= vld_reg[5];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        t_pipe_reg[0] <= mid.t;
        for (int i = 1; i < 6; i++)
        begin
            t_pipe_reg[i] <= t_pipe_reg[i-1];
        end

        plo7_reg   <= plo_next;
        phi7_reg   <= phi_next;
        odiff7_reg <= mid.odiff;

        prod8_reg  <= prod_next;
        odiff8_reg <= odiff7_reg;

        p1_9_reg   <= p1_next;
        odiff9_reg <= odiff8_reg;

        q10_reg    <= q_next;

        mag11_reg  <= mag_next;
        neg11_reg  <= q10_reg[Q_W-1];

        rp12_reg   <= rp_next;
        neg12_reg  <= neg11_reg;

        pressure_mbar     <= p_next;
        temperature_centi <= t_next;
        out_of_range      <= p_sat | t_sat;
    end

    assign done = done_reg;

endmodule

### dv/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Watches the coefficient writes, the pair transfers and the result transfers
// of the compensation block. It predicts each reading from its own copy of
// the coefficients and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module psc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psc_pkg::COEF_W-1:0]          cfg_data,
    input  logic                                start,
    input  logic                                busy,
    input  logic [psc_pkg::RAW_W-1:0]           pressure_raw,
    input  logic [psc_pkg::RAW_W-1:0]           temperature_raw,
    input  logic                                done,
    input  logic signed [psc_pkg::P_W-1:0]      pressure_mbar,
    input  logic signed [psc_pkg::TC_W-1:0]     temperature_centi,
    input  logic                                out_of_range,
    output int                                  error_count,
    output int                                  pending_readings
);

    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    // scale factors of the compensation equations
    localparam longint TEMP_SCALE   = 64'sd8388608;      // 2^23
    localparam longint OFF_SCALE    = 64'sd131072;       // 2^17
    localparam longint OFF_TC_SCALE = 64'sd64;           // 2^6
    localparam longint SENS_SCALE   = 64'sd65536;        // 2^16
    localparam longint SENS_TC_SCALE = 64'sd128;         // 2^7
    localparam longint TI_SCALE     = 64'sd34359738368;  // 2^35
    localparam longint PROD_SCALE   = 64'sd2097152;      // 2^21
    localparam longint PRESS_SCALE  = 64'sd32768;        // 2^15
    localparam longint TEMP_POINT   = 64'sd2000;         // 20.00 degrees
    localparam longint PRESS_LO     = -64'sd1048576;
    localparam longint PRESS_HI     = 64'sd1048575;
    localparam longint CENTI_LO     = -64'sd262144;
    localparam longint CENTI_HI     = 64'sd262143;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [P_W-1:0]  pressure;
        logic signed [TC_W-1:0] temperature;
        logic                   clipped;
    } reading_t;

    psc_coeff_t cal;
    reading_t   expected_readings[$];
    int         reported;

    // second-order compensation of one raw pair
    function automatic reading_t compensate_pair(input logic [RAW_W-1:0] d1_raw,
                                                 input logic [RAW_W-1:0] d2_raw,
                                                 input psc_coeff_t c);
        longint d1, d2, dt, temp, off, sens, ti, offi, sensi, dev, p, t;
        longint c1, c2, c3, c4, c5, c6;
        logic clipped;
        reading_t r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = c.sens;
        c2 = c.off;
        c3 = c.sens_temp;
        c4 = c.off_temp;
        c5 = c.ref_t;
        c6 = c.temp_sens;
        dt   = d2 - c5 * 256;
        temp = TEMP_POINT + (dt * c6) / TEMP_SCALE;
        off  = c2 * OFF_SCALE + (c4 * dt) / OFF_TC_SCALE;
        sens = c1 * SENS_SCALE + (c3 * dt) / SENS_TC_SCALE;
        ti = 0;
        offi = 0;
        sensi = 0;
        // low temperature correction terms
        if (temp < TEMP_POINT) begin
            dev   = temp - TEMP_POINT;
            ti    = (11 * dt * dt) / TI_SCALE;
            offi  = (31 * dev * dev) / 8;
            sensi = (63 * dev * dev) / 32;
        end
        p = (d1 * (sens - sensi)) / PROD_SCALE;
        p = ((p - (off - offi)) / PRESS_SCALE) / 100;
        t = temp - ti;
        // saturation of both outputs
        clipped = 1'b0;
        if (p < PRESS_LO) begin
            p = PRESS_LO;
            clipped = 1'b1;
        end
        else if (p > PRESS_HI) begin
            p = PRESS_HI;
            clipped = 1'b1;
        end
        if (t < CENTI_LO) begin
            t = CENTI_LO;
            clipped = 1'b1;
        end
        else if (t > CENTI_HI) begin
            t = CENTI_HI;
            clipped = 1'b1;
        end
        r.pressure    = p[P_W-1:0];
        r.temperature = t[TC_W-1:0];
        r.clipped     = clipped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            cal = '0;
            expected_readings.delete();
            reported = 0;
            error_count <= 0;
            pending_readings <= 0;
        end
        else
        begin
            // pair transfer: predict with the coefficients in use now
            if (start && !busy)
                expected_readings.push_back(compensate_pair(pressure_raw, temperature_raw, cal));

            // result transfer
            if (done)
            begin
                if (expected_readings.size() == 0)
                begin
                    if (reported < REPORT_LIMIT)
                        $display("unexpected result: pressure %0d temperature %0d flag %0b",
                                 pressure_mbar, temperature_centi, out_of_range);
                    reported = reported + 1;
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (pressure_mbar !== want.pressure ||
                        temperature_centi !== want.temperature ||
                        out_of_range !== want.clipped)
                    begin
                        if (reported < REPORT_LIMIT)
                            $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                     want.pressure, want.temperature, want.clipped,
                                     pressure_mbar, temperature_centi, out_of_range);
                        reported = reported + 1;
                        error_count <= error_count + 1;
                    end
                end
            end

            // coefficient write, spare indexes are ignored
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SENS_COEFF:      cal.sens      = cfg_data;
                    REG_OFF_COEFF:       cal.off       = cfg_data;
                    REG_SENS_TEMP_COEFF: cal.sens_temp = cfg_data;
                    REG_OFF_TEMP_COEFF:  cal.off_temp  = cfg_data;
                    REG_REF_TEMP:        cal.ref_t     = cfg_data;
                    REG_TEMP_SENS_COEFF: cal.temp_sens = cfg_data;
                    default: ;
                endcase
            end

            pending_readings <= expected_readings.size();
        end
    end

endmodule

### dv/pressure_sensor_compensation_tb.sv
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_tb
// Drives coefficient sets and raw conversion pairs into the compensation
// block: reset values, directed extremes and threshold pairs first, then
// random phases, all but the last with random idle gaps. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam logic [RAW_W-1:0]     RAW_MAX     = {RAW_W{1'b1}};
    localparam logic [COEF_W-1:0]    COEF_MAX    = {COEF_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_0 = CFG_IDX_W'(REG_TEMP_SENS_COEFF + 1);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_1 = CFG_IDX_W'(REG_TEMP_SENS_COEFF + 2);
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 110;
    localparam int DRAIN_SLACK     = 32;
    localparam int WATCHDOG_LIMIT  = 1000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [COEF_W-1:0]     cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [RAW_W-1:0]      pressure_raw = '0;
    logic [RAW_W-1:0]      temperature_raw = '0;
    logic                  done;
    logic signed [P_W-1:0] pressure_mbar;
    logic signed [TC_W-1:0] temperature_centi;
    logic                  out_of_range;
    int                    error_count;
    int                    pending_readings;
    int                    stall_cycles = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pressure_sensor_compensation DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .pressure_raw     (pressure_raw),
        .temperature_raw  (temperature_raw),
        .done             (done),
        .pressure_mbar    (pressure_mbar),
        .temperature_centi(temperature_centi),
        .out_of_range     (out_of_range)
    );

    psc_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .pressure_raw     (pressure_raw),
        .temperature_raw  (temperature_raw),
        .done             (done),
        .pressure_mbar    (pressure_mbar),
        .temperature_centi(temperature_centi),
        .out_of_range     (out_of_range),
        .error_count      (error_count),
        .pending_readings (pending_readings)
    );

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d readings outstanding", pending_readings);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic psc_coeff_t make_cal(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6);
        return {c1, c2, c3, c4, c5, c6};
    endfunction

    function automatic psc_coeff_t random_cal();
        return {16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()), 16'($urandom()), 16'($urandom())};
    endfunction

    // temperature reading close to the reference point, both sides
    function automatic logic [RAW_W-1:0] near_ref(input psc_coeff_t c, input int span);
        int v;
        v = int'(c.ref_t) * 256 + $urandom_range(0, 2 * span) - span;
        if (v < 0)
            v = 0;
        else if (v > int'(RAW_MAX))
            v = int'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    // write all six coefficients, then the spare indexes with junk
    task automatic load_cal(input psc_coeff_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SENS_COEFF;      cfg_data <= c.sens;      @(posedge clk);
        cfg_index <= REG_OFF_COEFF;       cfg_data <= c.off;       @(posedge clk);
        cfg_index <= REG_SENS_TEMP_COEFF; cfg_data <= c.sens_temp; @(posedge clk);
        cfg_index <= REG_OFF_TEMP_COEFF;  cfg_data <= c.off_temp;  @(posedge clk);
        cfg_index <= REG_REF_TEMP;        cfg_data <= c.ref_t;     @(posedge clk);
        cfg_index <= REG_TEMP_SENS_COEFF; cfg_data <= c.temp_sens; @(posedge clk);
        cfg_index <= IDX_SPARE_0;         cfg_data <= 16'($urandom()); @(posedge clk);
        cfg_index <= IDX_SPARE_1;         cfg_data <= 16'($urandom()); @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // one pair transfer, with an optional idle burst before it
    task automatic send_pair(input logic [RAW_W-1:0] d1, d2, input bit idle_ok);
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start           <= 1'b1;
        pressure_raw    <= d1;
        temperature_raw <= d2;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random pair: full range, near the threshold, or extremes
    task automatic send_random(input psc_coeff_t c, input bit idle_ok);
        int sel;
        logic [RAW_W-1:0] d1, d2;
        sel = $urandom_range(0, 9);
        d1 = RAW_W'($urandom());
        if (sel < 4)
            d2 = RAW_W'($urandom());
        else if (sel < 8)
            d2 = near_ref(c, 4096);
        else
        begin
            d2 = ($urandom_range(0, 1) != 0) ? RAW_MAX : '0;
            d1 = ($urandom_range(0, 1) != 0) ? RAW_MAX : d1;
        end
        send_pair(d1, d2, idle_ok);
    endtask

    // wait until every prediction is matched and the pipeline is quiet
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_readings != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    initial
    begin
        psc_coeff_t cal;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients are all zero
        send_pair('0, '0, 1'b0);
        send_pair(RAW_MAX, RAW_MAX, 1'b0);
        send_pair(24'd4958179, 24'd6815414, 1'b0);
        drain();

        // typical calibration: corners and the 20.00 degree threshold
        cal = make_cal(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
        load_cal(cal);
        send_pair('0, '0, 1'b0);
        send_pair(RAW_MAX, RAW_MAX, 1'b0);
        send_pair('0, RAW_MAX, 1'b0);
        send_pair(RAW_MAX, '0, 1'b0);
        send_pair(24'd4958179, 24'd6815414, 1'b0);
        send_pair(24'd4958179, {cal.ref_t, 8'd0}, 1'b0);
        send_pair(24'd4958179, {cal.ref_t, 8'd0} - 24'd1, 1'b0);
        send_pair(24'd4958179, {cal.ref_t, 8'd0} - 24'd400, 1'b0);
        send_pair(24'd4958179, {cal.ref_t, 8'd0} + 24'd400, 1'b0);
        drain();

        // all coefficients at maximum
        cal = make_cal(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        load_cal(cal);
        send_pair('0, '0, 1'b0);
        send_pair(RAW_MAX, '0, 1'b0);
        send_pair(RAW_MAX, RAW_MAX, 1'b0);
        send_pair(RAW_MAX, {cal.ref_t, 8'd0}, 1'b0);
        drain();

        // zero written explicitly, maximum reference temperature
        cal = make_cal('0, '0, '0, '0, COEF_MAX, '0);
        load_cal(cal);
        send_pair(RAW_MAX, '0, 1'b0);
        send_pair(RAW_MAX, RAW_MAX, 1'b0);
        drain();

        // random phases, the last one without idle gaps
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 5)
                1:       cal = make_cal(COEF_MAX, '0, COEF_MAX, '0, 16'($urandom()), COEF_MAX);
                3:       cal = make_cal('0, COEF_MAX, '0, COEF_MAX, 16'($urandom()), COEF_MAX);
                default: cal = random_cal();
            endcase
            load_cal(cal);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random(cal, ph != RANDOM_PHASES - 1);
            drain();
        end

        if (error_count == 0 && pending_readings == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
